[hdl/hdr3m_pkg.sv]
// ----------------------------------------------------------------------------
// hdr3m_pkg
// shared types and constants of the three-exposure hdr merge
// ----------------------------------------------------------------------------
package hdr3m_pkg;

    localparam int SAT_BITS       = 16;
    localparam int GAIN_BITS      = 24;
    localparam int GAIN_FRAC_BITS = 16;
    localparam int QUOT_BITS      = 32;
    localparam int CFG_IDX_BITS   = 2;
    localparam int CFG_DATA_BITS  = 24;
    localparam int PORT_PIX_BITS  = 16;
    localparam int NUM_EXP        = 3;

    localparam logic [CFG_IDX_BITS-1:0] REG_SAT_LEVEL = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_GAIN_1ST  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_GAIN_2ND  = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_GAIN_3RD  = 2'd3;

    localparam logic [SAT_BITS-1:0]  SAT_RESET  = 16'hFFFF;
    localparam logic [GAIN_BITS-1:0] GAIN_RESET = 24'h010000;

    typedef struct packed {
        logic neg;
        logic no_wt;
        logic ovf;
    } hdr3m_tag_t;

endpackage

[hdl/hdr_three_exposure_merge.sv]
// ----------------------------------------------------------------------------
// hdr_three_exposure_merge
// hat-weighted average of three co-located exposures, q24.8 result
// ----------------------------------------------------------------------------
// usage:
//   registers are written through cfg_write / cfg_index / cfg_data while no
//   request is in flight: saturation level, then three q8.16 inverse gains.
//   a request is taken on a clock edge with start high and busy low; busy
//   stays low, so one request per clock is accepted.
//   each request gives exactly one result: done is high for one cycle with
//   merged_value, no_weight and clipped valid in that cycle.
//   the path from the accepting edge to the edge that takes
//   the result: five arithmetic stages (weights and scaling, partial products,
//   term assembly, summing, magnitude), a divider input register, 32 divider
//   stages of one quotient bit each, and the output register. throughput is
//   one result per clock.
//   the receiver cannot stall; results are shown for exactly one cycle.
//   reset clears all valid bits and loads the register reset values; items
//   in flight at reset are dropped.
// ----------------------------------------------------------------------------
module hdr_three_exposure_merge #(
    parameter int PIXEL_BITS    = 16,
    parameter int OUT_FRAC_BITS = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [hdr3m_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [hdr3m_pkg::CFG_DATA_BITS-1:0] cfg_data,
    input  logic                                start,
    output logic                                busy,
    input  logic [hdr3m_pkg::PORT_PIX_BITS-1:0] pixel_first,
    input  logic [hdr3m_pkg::PORT_PIX_BITS-1:0] pixel_second,
    input  logic [hdr3m_pkg::PORT_PIX_BITS-1:0] pixel_third,
    output logic                                done,
    output logic [hdr3m_pkg::QUOT_BITS-1:0]     merged_value,
    output logic                                no_weight,
    output logic                                clipped
);
    import hdr3m_pkg::*;

    localparam int PB   = PIXEL_BITS;
    localparam int WW   = PB + SAT_BITS + 1;
    localparam int MW   = PB + SAT_BITS;
    localparam int SW   = PB + GAIN_BITS;
    localparam int SL   = SW / 2;
    localparam int SH   = SW - SL;
    localparam int TW   = MW + SW;
    localparam int NW   = TW + 3;
    localparam int DSW  = WW + 2;
    localparam int DNW  = WW + 1;
    localparam int DW   = DNW + GAIN_FRAC_BITS;
    localparam int NNW  = NW - 1 + OUT_FRAC_BITS;
    localparam int LATENCY = 6 + QUOT_BITS + 1;

    // configuration
    logic [SAT_BITS-1:0]  sat_reg;
    logic [GAIN_BITS-1:0] gain_reg [NUM_EXP];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sat_reg <= SAT_RESET;
            for (int i = 0; i < NUM_EXP; i++)
            begin
                gain_reg[i] <= GAIN_RESET;
            end
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_SAT_LEVEL: sat_reg     <= cfg_data[SAT_BITS-1:0];
                REG_GAIN_1ST:  gain_reg[0] <= cfg_data[GAIN_BITS-1:0];
                REG_GAIN_2ND:  gain_reg[1] <= cfg_data[GAIN_BITS-1:0];
                REG_GAIN_3RD:  gain_reg[2] <= cfg_data[GAIN_BITS-1:0];
                default:       sat_reg     <= sat_reg;
            endcase
        end
    end

    assign busy = 1'b0;

    // stage a: weights and scaled pixels
    logic [PB-1:0]           pix     [NUM_EXP];
    logic signed [SAT_BITS:0] diff   [NUM_EXP];
    logic signed [WW-1:0]    w_next  [NUM_EXP];
    logic [SW-1:0]           s_next  [NUM_EXP];
    logic                    a_vld_reg;
    logic signed [WW-1:0]    w_a_reg [NUM_EXP];
    logic [SW-1:0]           s_a_reg [NUM_EXP];

    always_comb
    begin
        pix[0] = pixel_first[PB-1:0];
        pix[1] = pixel_second[PB-1:0];
        pix[2] = pixel_third[PB-1:0];
        for (int i = 0; i < NUM_EXP; i++)
        begin
            diff[i]   = $signed({1'b0, sat_reg})
                      - $signed({{(SAT_BITS + 1 - PB){1'b0}}, pix[i]});
            w_next[i] = $signed({1'b0, pix[i]}) * diff[i];
            s_next[i] = {{GAIN_BITS{1'b0}}, pix[i]} * {{PB{1'b0}}, gain_reg[i]};
        end
    end

    // stage b: partial products and weight sum
    logic [WW-1:0]         w_neg   [NUM_EXP];
    logic [MW-1:0]         w_mag   [NUM_EXP];
    logic signed [DSW-1:0] den_next;
    logic                  b_vld_reg;
    logic [MW+SL-1:0]      pl_b_reg [NUM_EXP];
    logic [MW+SH-1:0]      ph_b_reg [NUM_EXP];
    logic                  neg_b_reg [NUM_EXP];
    logic signed [DSW-1:0] den_b_reg;

    always_comb
    begin
        den_next = '0;
        for (int i = 0; i < NUM_EXP; i++)
        begin
            w_neg[i] = -w_a_reg[i];
            w_mag[i] = w_a_reg[i][WW-1] ? w_neg[i][MW-1:0] : w_a_reg[i][MW-1:0];
            den_next = den_next + DSW'(w_a_reg[i]);
        end
    end

    // stage c: signed terms
    logic [TW-1:0]        t_mag  [NUM_EXP];
    logic                 c_vld_reg;
    logic signed [NW-1:0] t_c_reg [NUM_EXP];
    logic signed [DSW-1:0] den_c_reg;

    always_comb
    begin
        for (int i = 0; i < NUM_EXP; i++)
        begin
            t_mag[i] = TW'(pl_b_reg[i]) + (TW'(ph_b_reg[i]) << SL);
        end
    end

    // stage d: numerator sum
    logic                  d_vld_reg;
    logic signed [NW-1:0]  num_d_reg;
    logic signed [DSW-1:0] den_d_reg;

    // stage e: magnitudes for the divider
    logic [NW-1:0]  num_neg;
    logic [NW-2:0]  num_mag;
    logic           e_vld_reg;
    logic [NNW-1:0] n_e_reg;
    logic [DW-1:0]  d_e_reg;
    hdr3m_tag_t     tag_e_reg;

    assign num_neg = -num_d_reg;
    assign num_mag = num_d_reg[NW-1] ? num_neg[NW-2:0] : num_d_reg[NW-2:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
            e_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg <= start && !busy;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
            d_vld_reg <= c_vld_reg;
            e_vld_reg <= d_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_EXP; i++)
        begin
            w_a_reg[i]   <= w_next[i];
            s_a_reg[i]   <= s_next[i];
            pl_b_reg[i]  <= w_mag[i] * s_a_reg[i][SL-1:0];
            ph_b_reg[i]  <= w_mag[i] * s_a_reg[i][SW-1:SL];
            neg_b_reg[i] <= w_a_reg[i][WW-1];
            t_c_reg[i]   <= neg_b_reg[i] ? -$signed(NW'(t_mag[i])) : $signed(NW'(t_mag[i]));
        end
        den_b_reg <= den_next;
        den_c_reg <= den_b_reg;
        num_d_reg <= t_c_reg[0] + t_c_reg[1] + t_c_reg[2];
        den_d_reg <= den_c_reg;
        n_e_reg   <= NNW'(num_mag) << OUT_FRAC_BITS;
        d_e_reg   <= {den_d_reg[DNW-1:0], {GAIN_FRAC_BITS{1'b0}}};
        tag_e_reg.neg   <= num_d_reg[NW-1];
        tag_e_reg.no_wt <= (den_d_reg <= 0);
        tag_e_reg.ovf   <= 1'b0;
    end

    // divider
    logic                 div_vld;
    logic [QUOT_BITS-1:0] div_q;
    hdr3m_tag_t           div_tag;

    hdr3m_div #(
        .NNW (NNW),
        .DW  (DW)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (e_vld_reg),
        .in_n    (n_e_reg),
        .in_d    (d_e_reg),
        .in_tag  (tag_e_reg),
        .out_vld (div_vld),
        .out_q   (div_q),
        .out_tag (div_tag)
    );

    // output stage
    logic                 done_reg;
    logic [QUOT_BITS-1:0] value_reg;
    logic [QUOT_BITS-1:0] value_next;
    logic                 no_weight_reg;
    logic                 clipped_reg;
    logic                 clipped_next;

    always_comb
    begin
        value_next   = '0;
        clipped_next = 1'b0;
        if (div_tag.no_wt)
        begin
            clipped_next = 1'b0;
        end
        else if (div_tag.ovf)
        begin
            clipped_next = 1'b1;
            value_next   = div_tag.neg ? '0 : '1;
        end
        else if (div_q != '0)
        begin
            clipped_next = div_tag.neg;
            value_next   = div_tag.neg ? '0 : div_q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= div_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg     <= value_next;
        no_weight_reg <= div_tag.no_wt;
        clipped_reg   <= clipped_next;
    end

    assign done         = done_reg;
    assign merged_value = value_reg;
    assign no_weight    = no_weight_reg;
    assign clipped      = clipped_reg;

    // checks
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("result missing after request");

    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(no_weight && clipped))
        else $error("no_weight and clipped together");

    a_no_weight_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && no_weight) |-> (merged_value == '0))
        else $error("nonzero value without weight");

    a_clip_value: assert property (@(posedge clk) disable iff (!rst_n)
        (done && clipped) |-> (merged_value == '0 || merged_value == '1))
        else $error("clipped value not at a limit");

endmodule

[hdl/hdr3m_div.sv]
// ----------------------------------------------------------------------------
// hdr3m_div
// pipelined restoring divider, one quotient bit per stage, with overflow check
// ----------------------------------------------------------------------------
module hdr3m_div #(
    parameter int NNW = 82,
    parameter int DW  = 50
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_vld,
    input  logic [NNW-1:0]             in_n,
    input  logic [DW-1:0]              in_d,
    input  hdr3m_pkg::hdr3m_tag_t      in_tag,
    output logic                       out_vld,
    output logic [hdr3m_pkg::QUOT_BITS-1:0] out_q,
    output hdr3m_pkg::hdr3m_tag_t      out_tag
);
    import hdr3m_pkg::*;

    localparam int TOPW = NNW - QUOT_BITS;
    localparam int CW   = (TOPW > DW) ? TOPW : DW;

    logic                 vld_reg  [0:QUOT_BITS];
    logic [DW-1:0]        rem_reg  [0:QUOT_BITS];
    logic [DW-1:0]        d_reg    [0:QUOT_BITS];
    logic [QUOT_BITS-1:0] low_reg  [0:QUOT_BITS];
    logic [QUOT_BITS-1:0] q_reg    [0:QUOT_BITS];
    hdr3m_tag_t           tag_reg  [0:QUOT_BITS];

    logic [CW-1:0] top_ext;
    logic [CW-1:0] d_ext;
    hdr3m_tag_t    tag_next;

    always_comb
    begin
        top_ext        = CW'(in_n[NNW-1:QUOT_BITS]);
        d_ext          = CW'(in_d);
        tag_next       = in_tag;
        tag_next.ovf   = (top_ext >= d_ext);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= top_ext[DW-1:0];
        d_reg[0]   <= in_d;
        low_reg[0] <= in_n[QUOT_BITS-1:0];
        q_reg[0]   <= '0;
        tag_reg[0] <= tag_next;
    end

    for (genvar k = 1; k <= QUOT_BITS; k++)
    begin : g_stage
        logic [DW:0] trial;
        logic [DW:0] diff;
        logic        take;

        always_comb
        begin
            trial = {rem_reg[k-1], low_reg[k-1][QUOT_BITS-1]};
            diff  = trial - {1'b0, d_reg[k-1]};
            take  = (trial >= {1'b0, d_reg[k-1]});
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k] <= take ? diff[DW-1:0] : trial[DW-1:0];
            d_reg[k]   <= d_reg[k-1];
            low_reg[k] <= {low_reg[k-1][QUOT_BITS-2:0], 1'b0};
            q_reg[k]   <= {q_reg[k-1][QUOT_BITS-2:0], take};
            tag_reg[k] <= tag_reg[k-1];
        end
    end

    assign out_vld = vld_reg[QUOT_BITS];
    assign out_q   = q_reg[QUOT_BITS];
    assign out_tag = tag_reg[QUOT_BITS];

endmodule

[dv/hdr_three_exposure_merge_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdr_three_exposure_merge_tb
// self-checking bench for the three-exposure hat-weighted hdr merge
// ----------------------------------------------------------------------------
// a short stimulus table runs first under the reset register values. Some of
// its rows carry hand-computed results; the other rows are checked against a
// local predictor of the weighted average. After that, random requests run
// in several register settings, the extremes among them. Registers are only
// written once the pipeline has drained. The sender pauses at random. Every
// result is compared in order against the queue of predicted results.
// ----------------------------------------------------------------------------
module hdr_three_exposure_merge_tb;
    import hdr3m_pkg::*;

    localparam int DRAIN_CYCLES = 45;
    localparam int CYCLE_LIMIT  = 300000;

    typedef struct packed {
        logic [31:0] value;
        logic        no_wt;
        logic        clip;
    } merge_result_t;

    typedef struct {
        logic [15:0]   p1, p2, p3;
        logic          typed;
        merge_result_t res;
    } pixel_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [23:0] cfg_data;
    logic        start;
    logic        busy;
    logic [15:0] pixel_first, pixel_second, pixel_third;
    logic        done;
    logic [31:0] merged_value;
    logic        no_weight;
    logic        clipped;

    logic [15:0] sat_level;
    logic [23:0] gain [3];

    merge_result_t merged_expected [$];
    logic          row_typed [$];
    merge_result_t row_result [$];
    int            mismatches;
    int            cycles;

    hdr_three_exposure_merge DUT (
        .clk(clk), .rst_n(rst_n), .cfg_write(cfg_write), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .start(start), .busy(busy), .pixel_first(pixel_first),
        .pixel_second(pixel_second), .pixel_third(pixel_third), .done(done),
        .merged_value(merged_value), .no_weight(no_weight), .clipped(clipped)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic merge_result_t predict_merge(logic [15:0] p1, logic [15:0] p2,
                                                    logic [15:0] p3);
        longint w1, w2, w3, den;
        logic signed [127:0] acc;
        logic [127:0] mag, quot;
        merge_result_t r;
        r = '0;
        w1 = longint'(p1) * (longint'(sat_level) - longint'(p1));
        w2 = longint'(p2) * (longint'(sat_level) - longint'(p2));
        w3 = longint'(p3) * (longint'(sat_level) - longint'(p3));
        den = w1 + w2 + w3;
        if (den <= 0)
        begin
            r.no_wt = 1'b1;
            return r;
        end
        acc = 128'(w1) * 128'(longint'(p1) * longint'(gain[0]))
            + 128'(w2) * 128'(longint'(p2) * longint'(gain[1]))
            + 128'(w3) * 128'(longint'(p3) * longint'(gain[2]));
        mag = acc[127] ? -acc : acc;
        quot = (mag << 8) / (128'(den) << GAIN_FRAC_BITS);
        if (quot == 0)
            r.value = '0;
        else if (acc[127])
            r.clip = 1'b1;
        else if (quot > 128'hFFFF_FFFF)
        begin
            r.value = 32'hFFFF_FFFF;
            r.clip = 1'b1;
        end
        else
            r.value = quot[31:0];
        return r;
    endfunction

    // request accepted: queue its result
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
        begin
            if (row_typed.pop_front())
                merged_expected.push_back(row_result.pop_front());
            else
            begin
                void'(row_result.pop_front());
                merged_expected.push_back(predict_merge(pixel_first, pixel_second, pixel_third));
            end
        end
    end

    always @(posedge clk)
    begin
        merge_result_t e;
        if (rst_n && done)
        begin
            if (merged_expected.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result value=%h", merged_value);
            end
            else
            begin
                e = merged_expected.pop_front();
                if (merged_value !== e.value || no_weight !== e.no_wt || clipped !== e.clip)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h/%b/%b actual %h/%b/%b",
                                 e.value, e.no_wt, e.clip, merged_value, no_weight, clipped);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [23:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_SAT_LEVEL: sat_level = data[15:0];
            REG_GAIN_1ST:  gain[0] = data;
            REG_GAIN_2ND:  gain[1] = data;
            default:       gain[2] = data;
        endcase
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (merged_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_pixels(logic [15:0] p1, logic [15:0] p2, logic [15:0] p3,
                               logic typed, merge_result_t res);
        int gap;
        gap = $urandom_range(3) == 0 ? 0 : $urandom_range(11);
        repeat (gap)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        row_typed.push_back(typed);
        row_result.push_back(res);
        start        <= 1'b1;
        pixel_first  <= p1;
        pixel_second <= p2;
        pixel_third  <= p3;
        do
            @(posedge clk);
        while (busy);
    endtask

    function automatic logic [15:0] pick_pixel(int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'(sat_level + $urandom_range(8) - 4);
            2: return 16'($urandom_range(255));
            default: return 16'(sat_level / 2 + $urandom_range(64));
        endcase
    endfunction

    function automatic logic [23:0] pick_gain();
        case ($urandom_range(4))
            0: return 24'h0;
            1: return 24'hFF_FFFF;
            2: return 24'h01_0000;
            default: return 24'($urandom);
        endcase
    endfunction

    pixel_row_t stim_table [] = '{
        '{16'd0,     16'd0,     16'd0,     1'b1, '{32'd0, 1'b1, 1'b0}},
        '{16'hFFFF,  16'hFFFF,  16'hFFFF,  1'b1, '{32'd0, 1'b1, 1'b0}},
        '{16'd1000,  16'd1000,  16'd1000,  1'b1, '{32'd256000, 1'b0, 1'b0}},
        '{16'd1,     16'd1,     16'd1,     1'b1, '{32'd256, 1'b0, 1'b0}},
        '{16'h8000,  16'h8000,  16'h8000,  1'b1, '{32'h0080_0000, 1'b0, 1'b0}},
        '{16'hAAAA,  16'h5555,  16'hAAAA,  1'b0, '0},
        '{16'h5555,  16'hAAAA,  16'h5555,  1'b0, '0},
        '{16'd0,     16'hFFFF,  16'd1,     1'b0, '0},
        '{16'hFFFE,  16'd0,     16'hFFFF,  1'b0, '0},
        '{16'd1,     16'd2,     16'hFFFE,  1'b0, '0},
        '{16'h7FFF,  16'h8000,  16'h0001,  1'b0, '0},
        '{16'h00FF,  16'hFF00,  16'h0F0F,  1'b0, '0}
    };

    initial
    begin
        int mode, n;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        start = 1'b0;
        pixel_first = '0;
        pixel_second = '0;
        pixel_third = '0;
        mismatches = 0;
        cycles = 0;
        sat_level = SAT_RESET;
        gain = '{GAIN_RESET, GAIN_RESET, GAIN_RESET};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_table[i])
            send_pixels(stim_table[i].p1, stim_table[i].p2, stim_table[i].p3,
                        stim_table[i].typed, stim_table[i].res);

        for (int phase = 0; phase < 9; phase++)
        begin
            start <= 1'b0;
            wait_drained();
            case (phase)
                0:
                begin
                    write_reg(REG_SAT_LEVEL, 24'hFFFF);
                    write_reg(REG_GAIN_1ST, 24'hFF_FFFF);
                    write_reg(REG_GAIN_2ND, 24'hFF_FFFF);
                    write_reg(REG_GAIN_3RD, 24'hFF_FFFF);
                end
                1:
                begin
                    write_reg(REG_SAT_LEVEL, 24'd1);
                    write_reg(REG_GAIN_1ST, 24'd0);
                    write_reg(REG_GAIN_2ND, 24'd0);
                    write_reg(REG_GAIN_3RD, 24'd0);
                end
                2:
                begin
                    write_reg(REG_SAT_LEVEL, 24'd0);
                    write_reg(REG_GAIN_2ND, 24'h01_0000);
                end
                default:
                begin
                    write_reg(REG_SAT_LEVEL, phase % 2 ? 24'($urandom_range(65535, 1))
                                                       : 24'($urandom_range(300, 1)));
                    write_reg(REG_GAIN_1ST, pick_gain());
                    write_reg(REG_GAIN_2ND, pick_gain());
                    write_reg(REG_GAIN_3RD, pick_gain());
                end
            endcase
            n = phase < 3 ? 60 : 180;
            for (int k = 0; k < n; k++)
            begin
                mode = $urandom_range(3);
                if ($urandom_range(5) == 0)
                begin
                    logic [15:0] p;
                    p = pick_pixel(mode);
                    send_pixels(p, p, p, 1'b0, '0);
                end
                else
                    send_pixels(pick_pixel(mode), pick_pixel($urandom_range(3)),
                                pick_pixel(mode), 1'b0, '0);
            end
        end

        start <= 1'b0;
        wait_drained();
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[filelist.f]
hdl/hdr3m_pkg.sv
hdl/hdr3m_div.sv
hdl/hdr_three_exposure_merge.sv
dv/hdr_three_exposure_merge_tb.sv
